### hdl/lgts_pkg.sv
// ----------------------------------------------------------------------------
// lgts_pkg
// Shared types and constants of the LDA Gibbs topic sampler.
// ----------------------------------------------------------------------------
package lgts_pkg;

	// input operation codes
	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_PLACE    = 2'd1;
	localparam logic [1:0] OP_RESAMPLE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DOC_PRIOR       = 2'd0;
	localparam logic [1:0] CFG_WORD_PRIOR      = 2'd1;
	localparam logic [1:0] CFG_VOCAB_PRIOR_SUM = 2'd2;
	localparam logic [1:0] CFG_TOPICS_IN_USE   = 2'd3;

	// configuration reset values
	localparam logic [31:0] RST_DOC_PRIOR       = 32'd32768;
	localparam logic [31:0] RST_WORD_PRIOR      = 32'd6554;
	localparam logic [31:0] RST_VOCAB_PRIOR_SUM = 32'd26843546;
	localparam logic [6:0]  RST_TOPICS_IN_USE   = 7'd64;

	// operand widths of the weight unit
	localparam int A_W  = 38;
	localparam int B_W  = 33;
	localparam int D_W  = 50;
	localparam int WT_W = 48;
	localparam int P_W  = A_W + B_W;
	localparam int AL_W = 19;

	localparam logic [WT_W-1:0] WT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_ECHO     = 2'd0,
		KIND_LOAD     = 2'd1,
		KIND_PLACE    = 2'd2,
		KIND_RESAMPLE = 2'd3
	} lgts_kind_t;

	typedef struct packed {
		lgts_kind_t  kind;
		logic [11:0] word_id;
		logic [7:0]  doc_id;
		logic [5:0]  topic_in;
		logic [19:0] count_value;
		logic [31:0] random_fraction;
	} lgts_cmd_t;

	typedef struct packed {
		logic [31:0] doc_prior;
		logic [31:0] word_prior;
		logic [31:0] vocab_prior_sum;
		logic [6:0]  topics_in_use;
	} lgts_cfg_t;

endpackage

### hdl/lda_gibbs_topic_sampler.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler
// Collapsed Gibbs topic resampler for held-out LDA inference.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  input    | in_valid / in_ready   | op, word_id, doc_id, topic_in,
//           |                       | count_value, random_fraction
//  result   | out_valid / out_ready | topic_out
//  config   | cfg_we                | cfg_addr, cfg_wdata
//
// A resample weighs each of the K topics in use in turn; the weight unit's
// divider works one bit a cycle. Load and place read, then write the counts;
// an out-of-range or unknown op is echoed back as topic_in. After reset a
// clearing pass zeroes the counts; no beat is taken meanwhile.
// A two-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_sampler import lgts_pkg::*; #(
	parameter int TOPICS = 64,
	parameter int VOCAB  = 4096,
	parameter int DOCS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] word_id,
	input  logic [7:0]  doc_id,
	input  logic [5:0]  topic_in,
	input  logic [19:0] count_value,
	input  logic [31:0] random_fraction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  topic_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	lgts_cfg_t cfg_q;
	lgts_cmd_t cmd;
	logic      cmd_valid;
	logic      cmd_pop;
	logic      init_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.doc_prior       <= RST_DOC_PRIOR;
			cfg_q.word_prior      <= RST_WORD_PRIOR;
			cfg_q.vocab_prior_sum <= RST_VOCAB_PRIOR_SUM;
			cfg_q.topics_in_use   <= RST_TOPICS_IN_USE;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_DOC_PRIOR:       cfg_q.doc_prior       <= cfg_wdata;
				CFG_WORD_PRIOR:      cfg_q.word_prior      <= cfg_wdata;
				CFG_VOCAB_PRIOR_SUM: cfg_q.vocab_prior_sum <= cfg_wdata;
				CFG_TOPICS_IN_USE:   cfg_q.topics_in_use   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	lgts_front #(.TOPICS(TOPICS), .VOCAB(VOCAB), .DOCS(DOCS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.init_done       (init_done),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.word_id         (word_id),
		.doc_id          (doc_id),
		.topic_in        (topic_in),
		.count_value     (count_value),
		.random_fraction (random_fraction),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop)
	);

	lgts_back #(.TOPICS(TOPICS), .VOCAB(VOCAB), .DOCS(DOCS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.topic_out (topic_out)
	);

	// no beat taken while the counts are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !in_ready)
		else $error("input taken during clearing pass");

	// no result can exist before any beat was taken
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !out_valid)
		else $error("result raised during clearing pass");

	// a queued command is only popped once clearing has finished
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> init_done && cmd_valid)
		else $error("command popped while clearing or queue empty");

endmodule

### hdl/lgts_ram.sv
// ----------------------------------------------------------------------------
// lgts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/lgts_front.sv
// ----------------------------------------------------------------------------
// lgts_front
// Accepts input beats, range-checks and classifies them, and queues them
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module lgts_front import lgts_pkg::*; #(
	parameter int TOPICS = 64,
	parameter int VOCAB  = 4096,
	parameter int DOCS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init_done,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] word_id,
	input  logic [7:0]  doc_id,
	input  logic [5:0]  topic_in,
	input  logic [19:0] count_value,
	input  logic [31:0] random_fraction,
	output logic        cmd_valid,
	output lgts_cmd_t   cmd,
	input  logic        cmd_pop
);

	lgts_cmd_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	lgts_cmd_t  cmd_in;
	logic       w_ok;
	logic       d_ok;
	logic       t_ok;
	logic       push;

	assign w_ok = 32'(word_id) < VOCAB;
	assign d_ok = 32'(doc_id) < DOCS;
	assign t_ok = 32'(topic_in) < TOPICS;

	always_comb begin
		cmd_in.word_id         = word_id;
		cmd_in.doc_id          = doc_id;
		cmd_in.topic_in        = topic_in;
		cmd_in.count_value     = count_value;
		cmd_in.random_fraction = random_fraction;
		case (op)
			OP_LOAD:     cmd_in.kind = (w_ok && t_ok) ? KIND_LOAD : KIND_ECHO;
			OP_PLACE:    cmd_in.kind = (w_ok && d_ok && t_ok) ? KIND_PLACE : KIND_ECHO;
			OP_RESAMPLE: cmd_in.kind = (w_ok && d_ok && t_ok) ? KIND_RESAMPLE : KIND_ECHO;
			default:     cmd_in.kind = KIND_ECHO;
		endcase
	end

	assign in_ready  = init_done && (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/lgts_weight.sv
// ----------------------------------------------------------------------------
// lgts_weight
// Topic weight unit: floor(a * b / d) saturated to 48 bits. Two-step split
// multiply, one saturation check, then a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module lgts_weight import lgts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [A_W-1:0]  a,
	input  logic [B_W-1:0]  b,
	input  logic [D_W-1:0]  d,
	output logic            done,
	output logic [WT_W-1:0] weight
);

	typedef enum logic [4:0] {
		WS_IDLE = 5'b00001,
		WS_MUL0 = 5'b00010,
		WS_MUL1 = 5'b00100,
		WS_CHK  = 5'b01000,
		WS_DIV  = 5'b10000
	} wt_state_t;

	wt_state_t       state_q;
	logic [A_W-1:0]  a_q;
	logic [B_W-1:0]  b_q;
	logic [D_W-1:0]  d_q;
	logic [P_W-1:0]  prod_q;
	logic [D_W-1:0]  rem_q;
	logic [WT_W-1:0] quo_q;
	logic [5:0]      cnt_q;
	logic            done_q;
	logic [WT_W-1:0] wt_q;
	logic [D_W-1:0]  prod_hi;
	logic [D_W:0]    rem_sh;
	logic            ge;

	assign prod_hi = D_W'(prod_q[P_W-1:WT_W]);
	assign rem_sh  = {rem_q, quo_q[WT_W-1]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign done    = done_q;
	assign weight  = wt_q;

	always_ff @(posedge clk) begin
		case (state_q)
			WS_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					d_q <= d;
				end
			end
			WS_MUL0: prod_q <= P_W'(a_q[AL_W-1:0] * b_q);
			WS_MUL1: prod_q <= prod_q + (P_W'(a_q[A_W-1:AL_W] * b_q) << AL_W);
			WS_CHK: begin
				rem_q <= prod_hi;
				quo_q <= prod_q[WT_W-1:0];
			end
			WS_DIV: begin
				rem_q <= ge ? D_W'(rem_sh - {1'b0, d_q}) : rem_sh[D_W-1:0];
				quo_q <= {quo_q[WT_W-2:0], ge};
			end
			default: ;
		endcase
		if (state_q == WS_CHK && (d_q == '0 || prod_hi >= d_q)) begin
			wt_q <= WT_MAX;
		end else if (state_q == WS_DIV && cnt_q == 6'(WT_W - 1)) begin
			wt_q <= {quo_q[WT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
			cnt_q   <= 6'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				WS_IDLE: if (start) state_q <= WS_MUL0;
				WS_MUL0: state_q <= WS_MUL1;
				WS_MUL1: state_q <= WS_CHK;
				WS_CHK: begin
					cnt_q <= 6'd0;
					if (d_q == '0 || prod_hi >= d_q) begin
						// quotient would not fit: saturate
						done_q  <= 1'b1;
						state_q <= WS_IDLE;
					end else begin
						state_q <= WS_DIV;
					end
				end
				WS_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(WT_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= WS_IDLE;
					end
				end
				default: state_q <= WS_IDLE;
			endcase
		end
	end

endmodule

### hdl/lgts_back.sv
// ----------------------------------------------------------------------------
// lgts_back
// Sequencer that owns the count memories: clearing pass, loads, placements,
// and the resample walk (remove, weigh all topics in use, scale, search, add back).
// ----------------------------------------------------------------------------
module lgts_back import lgts_pkg::*; #(
	parameter int TOPICS = 64,
	parameter int VOCAB  = 4096,
	parameter int DOCS   = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lgts_cfg_t cfg,
	input  logic      cmd_valid,
	input  lgts_cmd_t cmd,
	output logic      cmd_pop,
	output logic      init_done,
	output logic      out_valid,
	input  logic      out_ready,
	output logic [5:0] topic_out
);

	localparam int WDEPTH = VOCAB * TOPICS;
	localparam int DDEPTH = DOCS * TOPICS;
	localparam int CDEPTH = (WDEPTH > DDEPTH) ? WDEPTH : DDEPTH;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int DAW    = $clog2(DDEPTH);
	localparam int TW     = $clog2(TOPICS);
	localparam int CLW    = $clog2(CDEPTH);

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_UPD_RD = 12'b000000000100,
		ST_UPD_WR = 12'b000000001000,
		ST_W_RD   = 12'b000000010000,
		ST_W_OPS  = 12'b000000100000,
		ST_W_WAIT = 12'b000001000000,
		ST_U_MUL0 = 12'b000010000000,
		ST_U_MUL1 = 12'b000100000000,
		ST_S_CHK  = 12'b001000000000,
		ST_S_CMP  = 12'b010000000000,
		ST_DONE   = 12'b100000000000
	} bk_state_t;

	typedef enum logic [1:0] {
		UPD_LOAD = 2'd0,
		UPD_INC  = 2'd1,
		UPD_DEC  = 2'd2
	} upd_mode_t;

	bk_state_t       state_q;
	upd_mode_t       mode_q;
	lgts_cmd_t       cmd_q;
	logic [WAW-1:0]  wbase_q;
	logic [DAW-1:0]  dbase_q;
	logic [TW-1:0]   idx_q;
	logic [TW-1:0]   j_q;
	logic [TW-1:0]   lo_q;
	logic [TW-1:0]   hi_q;
	logic [WT_W-1:0] sum_q;
	logic [55:0]     uacc_q;
	logic [WT_W-1:0] u_q;
	logic [CLW-1:0]  clr_q;
	logic            out_valid_q;
	logic [5:0]      topic_out_q;

	logic [TW-1:0]   kuse_m1;
	logic [TW-1:0]   topic_sel;
	logic [TW-1:0]   mid;
	logic [WAW-1:0]  w_addr;
	logic [DAW-1:0]  d_addr;
	logic            clearing;
	logic            last_clr;
	logic            rd_cnt;

	logic            w_we;
	logic [WAW-1:0]  w_waddr;
	logic [39:0]     w_wdata;
	logic [39:0]     w_rdata;
	logic            d_we;
	logic [DAW-1:0]  d_waddr;
	logic [15:0]     d_wdata;
	logic [15:0]     d_rdata;
	logic            t_we;
	logic [TW-1:0]   t_waddr;
	logic [63:0]     t_wdata;
	logic [63:0]     t_rdata;
	logic            c_we;
	logic [WT_W-1:0] c_rdata;

	logic [19:0]     tr_cnt;
	logic [19:0]     nw_cnt;
	logic [31:0]     tt_cnt;
	logic [31:0]     nt_cnt;
	logic [32:0]     load_sum;
	logic [A_W-1:0]  op_a;
	logic [B_W-1:0]  op_b;
	logic [D_W-1:0]  op_d;
	logic            wt_start;
	logic            wt_done;
	logic [WT_W-1:0] wt_val;
	logic [WT_W:0]   sum_ext;
	logic [WT_W-1:0] sum_next;
	logic [79:0]     u_full;
	logic            can_emit;

	// clamp the configured topic count to 1..TOPICS
	always_comb begin
		if (cfg.topics_in_use == 7'd0) begin
			kuse_m1 = '0;
		end else if (32'(cfg.topics_in_use) > TOPICS) begin
			kuse_m1 = TW'(TOPICS - 1);
		end else begin
			kuse_m1 = TW'(cfg.topics_in_use - 7'd1);
		end
	end

	assign clearing  = state_q == ST_CLEAR;
	assign last_clr  = 32'(clr_q) == CDEPTH - 1;
	assign init_done = !clearing;
	assign topic_sel = (state_q == ST_W_RD) ? j_q : idx_q;
	assign mid       = TW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign w_addr    = wbase_q + WAW'(topic_sel);
	assign d_addr    = dbase_q + DAW'(topic_sel);
	assign rd_cnt    = state_q == ST_UPD_RD || state_q == ST_W_RD;
	assign cmd_pop   = state_q == ST_IDLE && cmd_valid;
	assign can_emit  = !out_valid_q || out_ready;

	assign tr_cnt   = w_rdata[39:20];
	assign nw_cnt   = w_rdata[19:0];
	assign tt_cnt   = t_rdata[63:32];
	assign nt_cnt   = t_rdata[31:0];
	assign load_sum = {1'b0, tt_cnt} + 33'(cmd_q.count_value);

	assign w_waddr = clearing ? WAW'(clr_q) : w_addr;
	assign d_waddr = clearing ? DAW'(clr_q) : d_addr;
	assign t_waddr = clearing ? TW'(clr_q) : idx_q;

	always_comb begin
		w_we    = 1'b0;
		d_we    = 1'b0;
		t_we    = 1'b0;
		w_wdata = '0;
		d_wdata = '0;
		t_wdata = '0;
		if (clearing) begin
			w_we = 32'(clr_q) < WDEPTH;
			d_we = 32'(clr_q) < DDEPTH;
			t_we = 32'(clr_q) < TOPICS;
		end else if (state_q == ST_UPD_WR) begin
			case (mode_q)
				UPD_LOAD: begin
					w_we    = 1'b1;
					t_we    = 1'b1;
					w_wdata = {cmd_q.count_value, nw_cnt};
					t_wdata = {load_sum[32] ? 32'hFFFF_FFFF : load_sum[31:0], nt_cnt};
				end
				UPD_INC: begin
					w_we    = 1'b1;
					d_we    = 1'b1;
					t_we    = 1'b1;
					w_wdata = {tr_cnt, (nw_cnt == '1) ? nw_cnt : nw_cnt + 20'd1};
					d_wdata = (d_rdata == '1) ? d_rdata : d_rdata + 16'd1;
					t_wdata = {tt_cnt, (nt_cnt == '1) ? nt_cnt : nt_cnt + 32'd1};
				end
				UPD_DEC: begin
					w_we    = 1'b1;
					d_we    = 1'b1;
					t_we    = 1'b1;
					w_wdata = {tr_cnt, (nw_cnt == '0) ? nw_cnt : nw_cnt - 20'd1};
					d_wdata = (d_rdata == '0) ? d_rdata : d_rdata - 16'd1;
					t_wdata = {tt_cnt, (nt_cnt == '0) ? nt_cnt : nt_cnt - 32'd1};
				end
				default: ;
			endcase
		end
	end

	// Q16.16 priors added to count operands: a is Q22.16, b Q17.16, d Q34.16
	assign op_a = A_W'({21'(tr_cnt) + 21'(nw_cnt), 16'h0000}) + A_W'(cfg.word_prior);
	assign op_b = B_W'({d_rdata, 16'h0000}) + B_W'(cfg.doc_prior);
	assign op_d = D_W'({33'(tt_cnt) + 33'(nt_cnt), 16'h0000}) + D_W'(cfg.vocab_prior_sum);

	assign wt_start = state_q == ST_W_OPS;
	assign sum_ext  = {1'b0, sum_q} + {1'b0, wt_val};
	assign sum_next = sum_ext[WT_W] ? WT_MAX : sum_ext[WT_W-1:0];
	assign c_we     = state_q == ST_W_WAIT && wt_done;
	assign u_full   = 80'(uacc_q) +
		(80'(cmd_q.random_fraction * sum_q[47:24]) << 24);

	lgts_ram #(.WIDTH(40), .DEPTH(WDEPTH)) u_word_mem (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (rd_cnt),
		.raddr (w_addr),
		.rdata (w_rdata)
	);

	lgts_ram #(.WIDTH(16), .DEPTH(DDEPTH)) u_doc_mem (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (rd_cnt),
		.raddr (d_addr),
		.rdata (d_rdata)
	);

	lgts_ram #(.WIDTH(64), .DEPTH(TOPICS)) u_total_mem (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (rd_cnt),
		.raddr (topic_sel),
		.rdata (t_rdata)
	);

	lgts_ram #(.WIDTH(WT_W), .DEPTH(TOPICS)) u_cum_mem (
		.clk   (clk),
		.we    (c_we),
		.waddr (j_q),
		.wdata (sum_next),
		.re    (state_q == ST_S_CHK),
		.raddr (mid),
		.rdata (c_rdata)
	);

	lgts_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wt_start),
		.a      (op_a),
		.b      (op_b),
		.d      (op_d),
		.done   (wt_done),
		.weight (wt_val)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q   <= cmd;
					wbase_q <= WAW'(WAW'(cmd.word_id) * WAW'(TOPICS));
					dbase_q <= DAW'(DAW'(cmd.doc_id) * DAW'(TOPICS));
					idx_q   <= TW'(cmd.topic_in);
					j_q     <= '0;
					sum_q   <= '0;
				end
			end
			ST_W_WAIT: begin
				if (wt_done) begin
					sum_q <= sum_next;
					j_q   <= j_q + TW'(1);
				end
			end
			ST_U_MUL0: uacc_q <= 56'(cmd_q.random_fraction * sum_q[23:0]);
			ST_U_MUL1: begin
				u_q  <= u_full[79:32];
				lo_q <= '0;
				hi_q <= kuse_m1;
			end
			ST_S_CHK: if (lo_q == hi_q) idx_q <= lo_q;
			ST_S_CMP: begin
				if (c_rdata > u_q) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + TW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= UPD_INC;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			topic_out_q <= '0;
		end else begin
			if (state_q == ST_DONE && can_emit) begin
				out_valid_q <= 1'b1;
				topic_out_q <= (cmd_q.kind == KIND_RESAMPLE) ? 6'(idx_q) : cmd_q.topic_in;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (last_clr) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_LOAD: begin
								mode_q  <= UPD_LOAD;
								state_q <= ST_UPD_RD;
							end
							KIND_PLACE: begin
								mode_q  <= UPD_INC;
								state_q <= ST_UPD_RD;
							end
							KIND_RESAMPLE: begin
								mode_q  <= UPD_DEC;
								state_q <= ST_UPD_RD;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_UPD_RD: state_q <= ST_UPD_WR;
				ST_UPD_WR: state_q <= (mode_q == UPD_DEC) ? ST_W_RD : ST_DONE;
				ST_W_RD:   state_q <= ST_W_OPS;
				ST_W_OPS:  state_q <= ST_W_WAIT;
				ST_W_WAIT: begin
					if (wt_done) begin
						state_q <= (j_q == kuse_m1) ? ST_U_MUL0 : ST_W_RD;
					end
				end
				ST_U_MUL0: state_q <= ST_U_MUL1;
				ST_U_MUL1: state_q <= ST_S_CHK;
				ST_S_CHK: begin
					if (lo_q == hi_q) begin
						// add the token back under the chosen topic
						mode_q  <= UPD_INC;
						state_q <= ST_UPD_RD;
					end else begin
						state_q <= ST_S_CMP;
					end
				end
				ST_S_CMP: state_q <= ST_S_CHK;
				ST_DONE:  if (can_emit) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign topic_out = topic_out_q;

endmodule
